// ===== rtl/core/isbm_pkg.sv =====
package isbm_pkg;

  localparam int BOUNDS         = 32;
  localparam int BOUNDARY_WIDTH = 32;
  localparam int PORT_WIDTH     = 32;
  localparam int CNT_W          = $clog2(BOUNDS + 1);
  localparam int ADDR_W         = $clog2(BOUNDS);

  // all-ones value marks the end of a list
  localparam logic [BOUNDARY_WIDTH-1:0] END_MARK = '1;

  typedef enum logic [1:0] {
    ACT_CLEAR,
    ACT_LEFT,
    ACT_RIGHT,
    ACT_MERGE
  } action_t;

  typedef enum logic [1:0] {
    OP_UNION,
    OP_INTER,
    OP_DIFF,
    OP_XOR
  } set_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_STEP
  } state_t;

  typedef struct packed {
    logic clear;
    logic app_left;
    logic app_right;
    logic merge_init;
    logic step;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic sweep_done;
  } status_t;

  function automatic logic apply_op(set_op_t op, logic a, logic b);
    logic r;
    case (op)
      OP_UNION: r = a | b;
      OP_INTER: r = a & b;
      OP_DIFF:  r = a & ~b;
      OP_XOR:   r = a ^ b;
      default:  r = a ^ b;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/isbm_ram.sv =====
module isbm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write one word, read one word registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/isbm_ctrl.sv =====
module isbm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        action,
  input  isbm_pkg::status_t status,
  output isbm_pkg::cmd_t    cmd,
  output logic              busy
);

  isbm_pkg::state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= isbm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      isbm_pkg::ST_IDLE: begin
        if (start) begin
          case (isbm_pkg::action_t'(action))
            isbm_pkg::ACT_CLEAR: cmd.clear     = 1'b1;
            isbm_pkg::ACT_LEFT:  cmd.app_left  = 1'b1;
            isbm_pkg::ACT_RIGHT: cmd.app_right = 1'b1;
            isbm_pkg::ACT_MERGE: begin
              cmd.merge_init = 1'b1;
              state_next     = isbm_pkg::ST_FETCH;
            end
            default: ;
          endcase
        end
      end
      // wait for the stores to present the current heads
      isbm_pkg::ST_FETCH: state_next = isbm_pkg::ST_STEP;
      isbm_pkg::ST_STEP: begin
        if (status.sweep_done) begin
          cmd.flush  = 1'b1;
          state_next = isbm_pkg::ST_IDLE;
        end else begin
          cmd.step   = 1'b1;
          state_next = isbm_pkg::ST_FETCH;
        end
      end
      default: state_next = isbm_pkg::ST_IDLE;
    endcase
  end

  assign busy = (state != isbm_pkg::ST_IDLE);

endmodule

// ===== rtl/core/isbm_dp.sv =====
module isbm_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  isbm_pkg::cmd_t                      cmd,
  input  logic [isbm_pkg::BOUNDARY_WIDTH-1:0] value,
  input  logic [1:0]                          set_op,
  output isbm_pkg::status_t                   status,
  output logic                                strobe,
  output logic [isbm_pkg::BOUNDARY_WIDTH-1:0] res_boundary,
  output logic                                last,
  output logic                                empty_res,
  output logic                                overflow
);

  localparam int BW = isbm_pkg::BOUNDARY_WIDTH;
  localparam int CW = isbm_pkg::CNT_W;
  localparam int AW = isbm_pkg::ADDR_W;

  logic [CW-1:0]     left_count, right_count;
  logic              dropped;
  logic [CW-1:0]     li, ri;
  logic              side;
  isbm_pkg::set_op_t op;
  logic              pend_valid;
  logic [BW-1:0]     pend;

  logic          left_we, right_we;
  logic [BW-1:0] left_rd, right_rd;
  logic          l_live, r_live;
  logic [BW-1:0] lhead, rhead, head;
  logic          lside, rside, in_l, in_r, keep, emit;

  assign left_we  = cmd.app_left  && (left_count  < CW'(isbm_pkg::BOUNDS));
  assign right_we = cmd.app_right && (right_count < CW'(isbm_pkg::BOUNDS));

  isbm_ram #(.WIDTH(BW), .DEPTH(isbm_pkg::BOUNDS)) u_left_ram (
    .clk   (clk),
    .we    (left_we),
    .waddr (left_count[AW-1:0]),
    .wdata (value),
    .raddr (li[AW-1:0]),
    .rdata (left_rd)
  );

  isbm_ram #(.WIDTH(BW), .DEPTH(isbm_pkg::BOUNDS)) u_right_ram (
    .clk   (clk),
    .we    (right_we),
    .waddr (right_count[AW-1:0]),
    .wdata (value),
    .raddr (ri[AW-1:0]),
    .rdata (right_rd)
  );

  // current heads; an exhausted list reads as the end mark on its lower side
  always_comb begin
    l_live = (li < left_count);
    r_live = (ri < right_count);
    lhead  = l_live ? left_rd : isbm_pkg::END_MARK;
    rhead  = r_live ? right_rd : isbm_pkg::END_MARK;
    lside  = l_live & li[0];
    rside  = r_live & ri[0];
    head   = (lhead < rhead) ? lhead : rhead;
    in_l   = ((head < lhead) == lside);
    in_r   = ((head < rhead) == rside);
    keep   = isbm_pkg::apply_op(op, in_l, in_r);
    emit   = (keep != side);
  end

  assign status.sweep_done = (head == isbm_pkg::END_MARK);

  // list counts and drop flag
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      left_count  <= '0;
      right_count <= '0;
      dropped     <= 1'b0;
    end else begin
      if (cmd.app_left) begin
        if (left_we) begin
          left_count <= left_count + CW'(1);
        end else begin
          dropped <= 1'b1;
        end
      end
      if (cmd.app_right) begin
        if (right_we) begin
          right_count <= right_count + CW'(1);
        end else begin
          dropped <= 1'b1;
        end
      end
    end
  end

  // sweep state: advance indexes, track result side, hold one word back
  always_ff @(posedge clk) begin
    if (rst) begin
      li         <= '0;
      ri         <= '0;
      side       <= 1'b0;
      pend_valid <= 1'b0;
    end else if (cmd.merge_init) begin
      li         <= '0;
      ri         <= '0;
      side       <= 1'b0;
      pend_valid <= 1'b0;
    end else if (cmd.step) begin
      if (head == lhead) begin
        li <= li + CW'(1);
      end
      if (head == rhead) begin
        ri <= ri + CW'(1);
      end
      if (emit) begin
        side       <= ~side;
        pend_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.merge_init) begin
      op <= isbm_pkg::set_op_t'(set_op);
    end
    if (cmd.step && emit) begin
      pend <= head;
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= (cmd.step && emit && pend_valid) || cmd.flush;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.flush) begin
      res_boundary <= pend_valid ? pend : '0;
      last         <= 1'b1;
      empty_res    <= ~pend_valid;
      overflow     <= dropped;
    end else if (cmd.step && emit && pend_valid) begin
      res_boundary <= pend;
      last         <= 1'b0;
      empty_res    <= 1'b0;
      overflow     <= dropped;
    end
  end

endmodule

// ===== rtl/core/interval_set_boundary_merge.sv =====
// Interval set boundary merge.
// Input channel: an item (action, boundary, set_op) is taken at a rising edge
// with start high and busy low. Clear and the two appends leave busy low, so
// loads may be issued every cycle. An append to a full list is dropped and
// sets the drop flag behind overflow until the next clear.
// A merge raises busy and walks both lists in ascending order. Each sweep
// step passes through a fetch state for the registered read of the left and
// right list memories, then a step state to compare the heads and decide
// the result toggle. A merge covers n <= 64 stored boundaries.
// Result channel: each result word appears for exactly one cycle with strobe
// high; the receiver cannot stall it. The final word of a merge carries last;
// it shows in the cycle busy falls. A merge with an empty result gives one
// word with empty_res and last set and out_boundary zero.
// Reset clears both list counts, the drop flag behind overflow and the
// controller; the list memories are not cleared and need no clearing pass.
module interval_set_boundary_merge (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action,
  input  logic [31:0] boundary,
  input  logic [1:0]  set_op,
  output logic        strobe,
  output logic [31:0] out_boundary,
  output logic        last,
  output logic        empty_res,
  output logic        overflow
);

  isbm_pkg::cmd_t                      cmd;
  isbm_pkg::status_t                   status;
  logic [isbm_pkg::BOUNDARY_WIDTH-1:0] res_boundary;

  isbm_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (action),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  isbm_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .value        (boundary[isbm_pkg::BOUNDARY_WIDTH-1:0]),
    .set_op       (set_op),
    .status       (status),
    .strobe       (strobe),
    .res_boundary (res_boundary),
    .last         (last),
    .empty_res    (empty_res),
    .overflow     (overflow)
  );

  assign out_boundary = isbm_pkg::PORT_WIDTH'(res_boundary);

endmodule

// ===== rtl/core/isbm_checker.sv =====
module isbm_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [1:0]  action,
  input logic        strobe,
  input logic [31:0] out_boundary,
  input logic        last,
  input logic        empty_res
);

  // accepted merge occupies the block
  a_merge_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (action == isbm_pkg::ACT_MERGE) |=> busy)
    else $error("merge accepted but busy not raised");

  // words only come out of a merge
  a_strobe_src: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("result word without a merge in progress");

  // empty result is a single zero word that closes the merge
  a_empty_word: assert property (@(posedge clk) disable iff (rst)
    strobe && empty_res |-> last && (out_boundary == 32'd0))
    else $error("empty result word malformed");

  // every merge ends with a last word
  a_merge_end: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) && !$past(rst) |-> strobe && last)
    else $error("merge ended without a last word");

endmodule

bind interval_set_boundary_merge isbm_checker u_isbm_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .action       (action),
  .strobe       (strobe),
  .out_boundary (out_boundary),
  .last         (last),
  .empty_res    (empty_res)
);
